// ===== rtl/gn2f_pkg.sv =====
// Shared types, constants and lookup tables of the fractal gradient noise block.
package gn2f_pkg;

  localparam int MAX_OCTAVES_DEF     = 8;
  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int PERS_W    = 16;
  localparam int OCT_W     = 4;
  localparam int CRD_W     = 32;
  localparam int OUT_W     = 21;
  localparam int AMP_W     = 16;
  localparam int ACC_W     = 24;
  localparam int NW        = 19;

  localparam logic [PERS_W-1:0] PERS_RESET = 16'd16384;
  localparam logic [PERS_W-1:0] PERS_MAX   = 16'd32768;
  localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;
  localparam logic [AMP_W-1:0]  AMP_FIRST  = 16'd32768;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 24'sd1048575;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -24'sd1048576;

  localparam logic signed [17:0] G_ONE  = 18'sd65536;
  localparam logic signed [17:0] G_SQ3H = 18'sd56756;
  localparam logic signed [17:0] G_HALF = 18'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERSISTENCE  = 1'b0,
    CFG_OCTAVE_COUNT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              adv;
    logic [PERS_W-1:0] pers;
    logic [OCT_W-1:0]  oct_cnt;
  } cell_ctl_t;

  typedef logic [7:0] perm_tab_t [256];
  typedef logic [3:0] grad_tab_t [256];

  localparam perm_tab_t PERM_TAB = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180};

  function automatic grad_tab_t build_grad_tab();
    grad_tab_t r;
    for (int i = 0; i < 256; i++) begin
      r[i] = 4'(PERM_TAB[i] % 12);
    end
    return r;
  endfunction

  localparam grad_tab_t GRAD_TAB = build_grad_tab();

  function automatic logic signed [17:0] grad_x(input logic [3:0] g);
    logic signed [17:0] r;
    unique case (g)
      4'd0:    r = G_ONE;
      4'd1:    r = -G_ONE;
      4'd2:    r = G_SQ3H;
      4'd3:    r = -G_SQ3H;
      4'd4:    r = G_HALF;
      4'd5:    r = -G_HALF;
      4'd8:    r = -G_HALF;
      4'd9:    r = G_HALF;
      4'd10:   r = -G_SQ3H;
      4'd11:   r = G_SQ3H;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] grad_y(input logic [3:0] g);
    logic signed [17:0] r;
    unique case (g)
      4'd2:    r = G_HALF;
      4'd3:    r = -G_HALF;
      4'd4:    r = G_SQ3H;
      4'd5:    r = -G_SQ3H;
      4'd6:    r = G_ONE;
      4'd7:    r = -G_ONE;
      4'd8:    r = G_SQ3H;
      4'd9:    r = -G_SQ3H;
      4'd10:   r = G_HALF;
      4'd11:   r = -G_HALF;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gradient_noise_2d_fractal.sv =====
// Top level of the fractal 2D gradient noise block: chain of octave cells.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------
//   in       | in_valid / in_ready      | coord_x, coord_y
//   out      | out_valid / out_ready    | noise_value
//   cfg      | cfg_we                   | cfg_index, cfg_data
//
// One point enters per cycle while the pipeline advances. The accepting edge loads
// the first of the eleven stages of octave cell 0, each further cell adds one
// register of skew, and the output register, which drives out_valid, adds one more.
// rst clears the valid line and resets the configuration registers.
// The whole pipeline holds while a result waits at the output register.
module gradient_noise_2d_fractal #(
  parameter int MAX_OCTAVES     = gn2f_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = gn2f_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [gn2f_pkg::CRD_W-1:0]    coord_x,
  input  logic signed [gn2f_pkg::CRD_W-1:0]    coord_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [gn2f_pkg::OUT_W-1:0]    noise_value,
  input  logic                                 cfg_we,
  input  logic [gn2f_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gn2f_pkg::CFG_W-1:0]           cfg_data
);
  import gn2f_pkg::*;

  localparam int LAT = MAX_OCTAVES + 10;

  logic [PERS_W-1:0] persistence;
  logic [OCT_W-1:0]  octave_count;
  logic              adv;
  logic [LAT-1:0]    vld;
  cell_ctl_t         ctl;

  logic [CRD_W-1:0]        x_c   [MAX_OCTAVES+1];
  logic [CRD_W-1:0]        y_c   [MAX_OCTAVES+1];
  logic [AMP_W-1:0]        amp_c [MAX_OCTAVES+1];
  logic signed [ACC_W-1:0] acc_c [MAX_OCTAVES+1];
  logic signed [ACC_W-1:0] acc;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign ctl.adv     = adv;
  assign ctl.pers    = persistence;
  assign ctl.oct_cnt = octave_count;

  assign x_c[0]   = coord_x;
  assign y_c[0]   = coord_y;
  assign amp_c[0] = AMP_FIRST;
  assign acc_c[0] = '0;
  assign acc      = acc_c[MAX_OCTAVES];

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
    gn2f_cell #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .OCT_IDX        (k)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .x_in   (x_c[k]),
      .y_in   (y_c[k]),
      .x_out  (x_c[k+1]),
      .y_out  (y_c[k+1]),
      .amp_in (amp_c[k]),
      .amp_out(amp_c[k+1]),
      .acc_in (acc_c[k]),
      .acc_out(acc_c[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      persistence  <= PERS_RESET;
      octave_count <= OCT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PERSISTENCE:  persistence  <= cfg_data[PERS_W-1:0];
        CFG_OCTAVE_COUNT: octave_count <= cfg_data[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[LAT-2:0], in_valid};
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc > OUT_MAX) begin
        noise_value <= OUT_W'(OUT_MAX);
      end else if (acc < OUT_MIN) begin
        noise_value <= OUT_W'(OUT_MIN);
      end else begin
        noise_value <= OUT_W'(acc);
      end
    end
  end

endmodule

// ===== rtl/gn2f_fade.sv =====
// Pipelined quintic fade curve 6t^5-15t^4+10t^3 in Q16, five stages.
module gn2f_fade (
  input  logic        clk,
  input  logic        adv,
  input  logic [15:0] t,
  output logic [16:0] f
);
  import gn2f_pkg::*;

  logic [15:0]        t1, t2;
  logic signed [21:0] a1;
  logic signed [38:0] pa2;
  logic [31:0]        pc2;
  logic [19:0]        b3;
  logic [31:0]        pd3;
  logic [35:0]        pf4;

  logic signed [38:0] rpa;
  logic [22:0]        bw;
  logic [31:0]        rc;
  logic [31:0]        rd;
  logic [36:0]        rf;
  logic [20:0]        fr;

  assign rpa = pa2 + 39'sd32768;
  assign bw  = rpa[38:16] + 23'd655360;
  assign rc  = pc2 + 32'd32768;
  assign rd  = pd3 + 32'd32768;
  assign rf  = 37'(pf4) + 37'd32768;
  assign fr  = rf[36:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      t1  <= t;
      a1  <= $signed(22'(t) * 22'd6 - 22'd983040);
      t2  <= t1;
      pa2 <= $signed({1'b0, t1}) * a1;
      pc2 <= t1 * t1;
      b3  <= bw[19:0];
      pd3 <= rc[31:16] * t2;
      pf4 <= rd[31:16] * b3;
      f   <= (fr > 21'd65536) ? 17'd65536 : fr[16:0];
    end
  end

endmodule

// ===== rtl/gn2f_cell.sv =====
// One octave cell: hashes, dot products, fade, blends and, when enabled, accumulates one octave.
module gn2f_cell #(
  parameter int COORD_FRAC_BITS = gn2f_pkg::COORD_FRAC_BITS_DEF,
  parameter int OCT_IDX         = 0
) (
  input  logic                               clk,
  input  gn2f_pkg::cell_ctl_t                ctl,
  input  logic [gn2f_pkg::CRD_W-1:0]         x_in,
  input  logic [gn2f_pkg::CRD_W-1:0]         y_in,
  output logic [gn2f_pkg::CRD_W-1:0]         x_out,
  output logic [gn2f_pkg::CRD_W-1:0]         y_out,
  input  logic [gn2f_pkg::AMP_W-1:0]         amp_in,
  output logic [gn2f_pkg::AMP_W-1:0]         amp_out,
  input  logic signed [gn2f_pkg::ACC_W-1:0]  acc_in,
  output logic signed [gn2f_pkg::ACC_W-1:0]  acc_out
);
  import gn2f_pkg::*;

  localparam int FW = COORD_FRAC_BITS;

  logic [7:0]  cx, cy;
  logic [15:0] tx, ty;
  logic [16:0] fx, fy;

  logic [7:0]  cx1, py0_1, py1_1;
  logic [15:0] tx1, ty1, tx2, ty2;
  logic [3:0]  g00, g10, g01, g11;
  logic signed [36:0] s00, s10, s01, s11;
  logic signed [36:0] r00, r10, r01, r11;
  logic signed [NW-1:0] n00, n10, n01, n11;
  logic signed [NW-1:0] n00_5, n10_5, n01_5, n11_5, n00_6, n01_6;
  logic signed [37:0] px0, px1, py8;
  logic signed [37:0] rx0, rx1, ry8;
  logic [16:0] fy6, fy7;
  logic signed [NW-1:0] l0, l1, l0_8, v;
  logic signed [19:0] d0, d1, dl;
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [35:0] prod;
  logic signed [35:0] rprod;
  logic [31:0] pamp;
  logic [31:0] ramp;
  logic en;

  logic [FW+15:0] fxw, fyw;

  assign cx  = x_in[FW+7:FW];
  assign cy  = y_in[FW+7:FW];
  assign fxw = {x_in[FW-1:0], 16'b0} >> FW;
  assign fyw = {y_in[FW-1:0], 16'b0} >> FW;
  assign tx  = fxw[15:0];
  assign ty  = fyw[15:0];

  assign dx0 = $signed({2'b00, tx2});
  assign dx1 = $signed({2'b11, tx2});
  assign dy0 = $signed({2'b00, ty2});
  assign dy1 = $signed({2'b11, ty2});

  assign r00 = s00 + 37'sd32768;
  assign r10 = s10 + 37'sd32768;
  assign r01 = s01 + 37'sd32768;
  assign r11 = s11 + 37'sd32768;

  assign d0  = 20'(n10_5) - 20'(n00_5);
  assign d1  = 20'(n11_5) - 20'(n01_5);
  assign rx0 = px0 + 38'sd32768;
  assign rx1 = px1 + 38'sd32768;
  assign dl  = 20'(l1) - 20'(l0);
  assign ry8 = py8 + 38'sd32768;

  assign pamp  = amp_in * ((ctl.pers > PERS_MAX) ? PERS_MAX : ctl.pers);
  assign ramp  = pamp + 32'd16384;
  assign rprod = prod + 36'sd16384;
  assign en    = (OCT_W'(OCT_IDX) < ctl.oct_cnt);

  gn2f_fade u_fade_x (.clk(clk), .adv(ctl.adv), .t(tx), .f(fx));
  gn2f_fade u_fade_y (.clk(clk), .adv(ctl.adv), .t(ty), .f(fy));

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      x_out <= {x_in[CRD_W-2:0], 1'b0};
      y_out <= {y_in[CRD_W-2:0], 1'b0};
      cx1   <= cx;
      py0_1 <= PERM_TAB[cy];
      py1_1 <= PERM_TAB[8'(cy + 8'd1)];
      tx1   <= tx;
      ty1   <= ty;

      g00 <= GRAD_TAB[8'(cx1 + py0_1)];
      g10 <= GRAD_TAB[8'(cx1 + py0_1 + 8'd1)];
      g01 <= GRAD_TAB[8'(cx1 + py1_1)];
      g11 <= GRAD_TAB[8'(cx1 + py1_1 + 8'd1)];
      tx2 <= tx1;
      ty2 <= ty1;

      s00 <= grad_x(g00) * dx0 + grad_y(g00) * dy0;
      s10 <= grad_x(g10) * dx1 + grad_y(g10) * dy0;
      s01 <= grad_x(g01) * dx0 + grad_y(g01) * dy1;
      s11 <= grad_x(g11) * dx1 + grad_y(g11) * dy1;

      n00 <= r00[NW+15:16];
      n10 <= r10[NW+15:16];
      n01 <= r01[NW+15:16];
      n11 <= r11[NW+15:16];

      n00_5 <= n00;
      n10_5 <= n10;
      n01_5 <= n01;
      n11_5 <= n11;

      px0   <= $signed({1'b0, fx}) * d0;
      px1   <= $signed({1'b0, fx}) * d1;
      n00_6 <= n00_5;
      n01_6 <= n01_5;
      fy6   <= fy;

      l0  <= NW'($signed(rx0[37:16]) + 22'(n00_6));
      l1  <= NW'($signed(rx1[37:16]) + 22'(n01_6));
      fy7 <= fy6;

      py8  <= $signed({1'b0, fy7}) * dl;
      l0_8 <= l0;

      v <= NW'($signed(ry8[37:16]) + 22'(l0_8));

      prod    <= v * $signed({1'b0, amp_in});
      amp_out <= ramp[30:15];

      acc_out <= en ? acc_in + ACC_W'($signed(rprod[35:15])) : acc_in;
    end
  end

endmodule
